// File: rtl/bwl_pkg.sv
// Shared types and codes for the bandwidth ledger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bwl_pkg;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_TIME   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NOSLOT = 2'd1;
	localparam logic [1:0] ST_ROLL   = 2'd2;

	localparam logic [1:0] VIEW_LAST = 2'd0;
	localparam logic [1:0] VIEW_MAX  = 2'd1;
	localparam logic [1:0] VIEW_HIST = 2'd2;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_FREEID = 2'd1;

	localparam logic [31:0] PERIOD_RESET = 32'd1000000;
	localparam logic [15:0] FREEID_RESET = 16'hFFFF;
	localparam logic [30:0] SAT_MAX      = 31'h7FFF_FFFF;

	typedef struct packed {
		logic cur;
		logic last;
		logic max;
		logic hist;
	} mem_we_t;

endpackage

// File: rtl/bwl_slots.sv
// Player slot table with owner match and first-free search.
// Depends on bwl_pkg.
`timescale 1ns / 1ps

module bwl_slots import bwl_pkg::*; #(
	parameter int NUM_SLOTS = 8,
	parameter int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   pid,
	input  logic [15:0]   free_id,
	input  logic          claim,
	input  logic [SW-1:0] claim_idx,
	input  logic          clear,
	output logic          hit,
	output logic [SW-1:0] hit_idx,
	output logic          free_found,
	output logic [SW-1:0] free_idx
);

	logic [15:0] owner_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) owner_q[i] <= FREEID_RESET;
		end else if (clear) begin
			for (int i = 0; i < NUM_SLOTS; i++) owner_q[i] <= free_id;
		end else if (claim) begin
			owner_q[claim_idx] <= pid;
		end
	end

	// lowest index wins: scan downward so the last hit assigned is the lowest
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (owner_q[i] == pid) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (owner_q[i] == free_id) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

endmodule

// File: rtl/bwl_mem.sv
// Counter memories: current, last period, maximum and history ring.
// Depends on bwl_pkg for the write-enable group.
`timescale 1ns / 1ps

module bwl_mem import bwl_pkg::*; #(
	parameter int CELLS  = 1170,
	parameter int HCELLS = 9360,
	parameter int CW     = $clog2(CELLS),
	parameter int HAW    = $clog2(HCELLS)
) (
	input  logic           clk,
	input  mem_we_t        we,
	input  logic [CW-1:0]  waddr,
	input  logic [HAW-1:0] hist_waddr,
	input  logic [30:0]    cur_wdata,
	input  logic [30:0]    copy_wdata,
	input  logic [30:0]    max_wdata,
	input  logic [CW-1:0]  raddr,
	input  logic [HAW-1:0] hist_raddr,
	output logic [30:0]    cur_rd,
	output logic [30:0]    last_rd,
	output logic [30:0]    max_rd,
	output logic [30:0]    hist_rd
);

	logic [30:0] cur_mem  [CELLS];
	logic [30:0] last_mem [CELLS];
	logic [30:0] max_mem  [CELLS];
	logic [30:0] hist_mem [HCELLS];

	always_ff @(posedge clk) begin
		if (we.cur) cur_mem[waddr] <= cur_wdata;
		cur_rd <= cur_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we.last) last_mem[waddr] <= copy_wdata;
		last_rd <= last_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we.max) max_mem[waddr] <= max_wdata;
		max_rd <= max_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we.hist) hist_mem[hist_waddr] <= copy_wdata;
		hist_rd <= hist_mem[hist_raddr];
	end

endmodule

// File: rtl/per_flow_bandwidth_ledger_core.sv
// Per-flow bandwidth ledger: top level sequencer around one shared saturating adder.
// A record runs dispatch, slot search, four read-modify-writes and the result. A rollover
// sweeps the cells one cell a cycle through the memory ports; clear wipes one history word a
// cycle. One word at a time; the next word may be accepted in the cycle done pulses. done
// pulses for one cycle. Reset: asynchronous, active low; after reset a clearing pass over
// every history word holds busy high. The receiver cannot stall results.
`timescale 1ns / 1ps

module per_flow_bandwidth_ledger_core import bwl_pkg::*; #(
	parameter int NUM_SLOTS     = 8,
	parameter int NUM_TYPES     = 64,
	parameter int HISTORY_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic        direction,
	input  logic [15:0] player_id,
	input  logic [6:0]  message_type,
	input  logic [15:0] bit_count,
	input  logic [31:0] current_time,
	input  logic [1:0]  view,
	input  logic [3:0]  player_row,
	input  logic [2:0]  history_slot,
	output logic        done,
	output logic [30:0] read_value,
	output logic [1:0]  status,
	output logic [2:0]  slot_index
);

	localparam int ROWS   = NUM_SLOTS + 1;
	localparam int COLS   = NUM_TYPES + 1;
	localparam int CELLS  = 2 * ROWS * COLS;
	localparam int HCELLS = HISTORY_DEPTH * CELLS;
	localparam int CW     = $clog2(CELLS);
	localparam int HAW    = $clog2(HCELLS);
	localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int HW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DISP    = 4'd2;
	localparam logic [3:0] S_FIND    = 4'd3;
	localparam logic [3:0] S_RMW_RD  = 4'd4;
	localparam logic [3:0] S_RMW_WR  = 4'd5;
	localparam logic [3:0] S_RD_OUT  = 4'd6;
	localparam logic [3:0] S_ROLL    = 4'd7;
	localparam logic [3:0] S_ROLL_END = 4'd8;

	logic [3:0]  state_q;
	logic [31:0] period_ticks_q;
	logic [15:0] free_id_q;
	logic [31:0] period_start_q;
	logic [HW-1:0] cursor_q;

	// latched word
	logic [1:0]  op_q;
	logic        dir_q;
	logic [15:0] pid_q;
	logic [6:0]  mtype_q;
	logic [15:0] bits_q;
	logic [31:0] now_q;
	logic [1:0]  view_q;
	logic [3:0]  row_q;
	logic [2:0]  hslot_q;

	logic [SW-1:0]  slot_q;
	logic [1:0]     k_q;
	logic [HAW-1:0] cnt_q;
	logic           roll_v_s1;
	logic [CW-1:0]  roll_addr_s1;

	logic [30:0] read_value_q;
	logic [1:0]  status_q;
	logic [2:0]  slot_index_q;
	logic        done_q;

	// slot table
	logic          hit, free_found, claim, slot_clear;
	logic [SW-1:0] hit_idx, free_idx;

	bwl_slots #(.NUM_SLOTS(NUM_SLOTS), .SW(SW)) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.pid        (pid_q),
		.free_id    (free_id_q),
		.claim      (claim),
		.claim_idx  (free_idx),
		.clear      (slot_clear),
		.hit        (hit),
		.hit_idx    (hit_idx),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	assign claim      = (state_q == S_FIND) && !hit && free_found;
	assign slot_clear = (state_q == S_DISP) && (op_q == OP_CLEAR);

	// memories
	mem_we_t        we;
	logic [CW-1:0]  waddr, raddr, rmw_idx, rd_idx;
	logic [HAW-1:0] hist_waddr, hist_raddr;
	logic [30:0]    cur_wdata, copy_wdata, max_wdata;
	logic [30:0]    cur_rd, last_rd, max_rd, hist_rd;

	bwl_mem #(.CELLS(CELLS), .HCELLS(HCELLS), .CW(CW), .HAW(HAW)) u_mem (
		.clk        (clk),
		.we         (we),
		.waddr      (waddr),
		.hist_waddr (hist_waddr),
		.cur_wdata  (cur_wdata),
		.copy_wdata (copy_wdata),
		.max_wdata  (max_wdata),
		.raddr      (raddr),
		.hist_raddr (hist_raddr),
		.cur_rd     (cur_rd),
		.last_rd    (last_rd),
		.max_rd     (max_rd),
		.hist_rd    (hist_rd)
	);

	// cell of the current record step: slot or total row, type or total column
	logic [CW-1:0] rmw_row, rmw_col;
	always_comb begin
		rmw_row = k_q[1] ? CW'(NUM_SLOTS) : CW'(slot_q);
		rmw_col = k_q[0] ? CW'(NUM_TYPES) : CW'(mtype_q);
		rmw_idx = (CW'(dir_q) * CW'(ROWS) + rmw_row) * CW'(COLS) + rmw_col;
	end

	// read cell: guard rows and columns beyond the tables
	logic rd_ok, hist_ok;
	assign rd_ok   = (32'(row_q) <= NUM_SLOTS) && (32'(mtype_q) <= NUM_TYPES);
	assign hist_ok = 32'(hslot_q) < HISTORY_DEPTH;
	assign rd_idx  = rd_ok ? (CW'(dir_q) * CW'(ROWS) + CW'(row_q)) * CW'(COLS) + CW'(mtype_q)
		: '0;

	always_comb begin
		case (state_q)
			S_ROLL:   raddr = cnt_q[CW-1:0];
			S_RMW_RD: raddr = rmw_idx;
			default:  raddr = rd_idx;
		endcase
		hist_raddr = hist_ok ? HAW'(hslot_q) * HAW'(CELLS) + HAW'(rd_idx) : '0;
	end

	// shared saturating adder
	logic [31:0] sum;
	assign sum = {1'b0, cur_rd} + 32'(bits_q);

	always_comb begin
		we         = '0;
		waddr      = rmw_idx;
		hist_waddr = HAW'(cursor_q) * HAW'(CELLS) + HAW'(roll_addr_s1);
		cur_wdata  = sum[31] ? SAT_MAX : sum[30:0];
		copy_wdata = cur_rd;
		max_wdata  = (max_rd < cur_rd) ? cur_rd : max_rd;
		if (state_q == S_CLR) begin
			// wipe one history word a cycle, the cell tables on the first CELLS of them
			hist_waddr = cnt_q;
			waddr      = cnt_q[CW-1:0];
			cur_wdata  = '0;
			copy_wdata = '0;
			max_wdata  = '0;
			we.hist    = 1'b1;
			we.cur     = 32'(cnt_q) < CELLS;
			we.last    = we.cur;
			we.max     = we.cur;
		end else if (roll_v_s1) begin
			// publish the cell read last cycle, then zero it
			waddr     = roll_addr_s1;
			cur_wdata = '0;
			we        = '{cur: 1'b1, last: 1'b1, max: 1'b1, hist: 1'b1};
		end else if (state_q == S_RMW_WR) begin
			we.cur = 1'b1;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ticks_q <= PERIOD_RESET;
			free_id_q      <= FREEID_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_PERIOD) period_ticks_q <= cfg_wdata;
			if (cfg_addr == REG_FREEID) free_id_q      <= cfg_wdata[15:0];
		end
	end

	// latch the word on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_RECORD;
			dir_q   <= 1'b0;
			pid_q   <= '0;
			mtype_q <= '0;
			bits_q  <= '0;
			now_q   <= '0;
			view_q  <= VIEW_LAST;
			row_q   <= '0;
			hslot_q <= '0;
		end else if (start && !busy) begin
			op_q    <= operation;
			dir_q   <= direction;
			pid_q   <= player_id;
			mtype_q <= message_type;
			bits_q  <= bit_count;
			now_q   <= current_time;
			view_q  <= view;
			row_q   <= player_row;
			hslot_q <= history_slot;
		end
	end

	logic [31:0] elapsed;
	assign elapsed = now_q - period_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			period_start_q <= '0;
			cursor_q       <= '0;
			slot_q         <= '0;
			k_q            <= '0;
			cnt_q          <= '0;
			roll_v_s1      <= 1'b0;
			roll_addr_s1   <= '0;
			done_q         <= 1'b0;
			read_value_q   <= '0;
			status_q       <= ST_DONE;
			slot_index_q   <= '0;
		end else begin
			done_q       <= 1'b0;
			roll_v_s1    <= 1'b0;
			roll_addr_s1 <= cnt_q[CW-1:0];
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == HCELLS - 1) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
						if (op_q == OP_CLEAR) done_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					read_value_q <= '0;
					status_q     <= ST_DONE;
					slot_index_q <= '0;
					k_q          <= '0;
					cnt_q        <= '0;
					case (op_q)
						OP_RECORD: begin
							if (32'(mtype_q) < NUM_TYPES) state_q <= S_FIND;
							else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						OP_TIME: begin
							if (elapsed > period_ticks_q) state_q <= S_ROLL;
							else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						OP_CLEAR: begin
							period_start_q <= now_q;
							cursor_q       <= '0;
							state_q        <= S_CLR;
						end
						default: state_q <= S_RD_OUT;
					endcase
				end
				S_FIND: begin
					if (hit) begin
						slot_q  <= hit_idx;
						state_q <= S_RMW_RD;
					end else if (free_found) begin
						slot_q  <= free_idx;
						state_q <= S_RMW_RD;
					end else begin
						status_q <= ST_NOSLOT;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						slot_index_q <= 3'(slot_q);
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_RMW_RD;
					end
				end
				S_RD_OUT: begin
					if (rd_ok) begin
						case (view_q)
							VIEW_LAST: read_value_q <= last_rd;
							VIEW_MAX:  read_value_q <= max_rd;
							VIEW_HIST: read_value_q <= hist_ok ? hist_rd : '0;
							default:   read_value_q <= '0;
						endcase
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_ROLL: begin
					roll_v_s1 <= 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					if (32'(cnt_q) == CELLS - 1) state_q <= S_ROLL_END;
				end
				S_ROLL_END: begin
					// last cell is written this cycle; then advance the ring
					period_start_q <= now_q;
					cursor_q <= (32'(cursor_q) == HISTORY_DEPTH - 1) ? '0 : cursor_q + 1'b1;
					status_q <= ST_ROLL;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;

	// an accepted word always holds the block busy the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a dropped record reports no slot
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOSLOT |-> slot_index == 3'd0 && read_value == 31'd0)
		else $error("dropped record carries a slot or value");

	// no memory write while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> we == '0)
		else $error("memory write while idle");

	// a rollover result only follows the rollover sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ROLL |-> $past(state_q) == S_ROLL_END)
		else $error("rollover status outside sweep");

endmodule
